// ===== rtl/itr_pkg.sv =====
// ----------------------------------------------------------------------------
// itr_pkg - shared types and constants for integer-to-Roman conversion
// Digit layout of a queued transaction, Roman digit patterns and letter codes.
// ----------------------------------------------------------------------------
package itr_pkg;

   localparam int NUM_W    = 12;
   localparam int SYM_W    = 8;
   localparam int PLACES   = 4;
   localparam int DIGIT_W  = 4;
   localparam int PLACE_W  = 2;
   localparam int UNIT_W   = 10;
   localparam int PLEN_W   = 3;

   localparam logic [NUM_W-1:0] ROMAN_MAX = 12'd3999;

   // ASCII letters
   localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;
   localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;
   localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
   localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
   localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
   localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
   localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
   localparam logic [SYM_W-1:0] SYM_I    = 8'h49;

   // Place indexes, most significant first
   localparam logic [PLACE_W-1:0] PLACE_THOUSANDS = 2'd0;
   localparam logic [PLACE_W-1:0] PLACE_HUNDREDS  = 2'd1;
   localparam logic [PLACE_W-1:0] PLACE_TENS      = 2'd2;
   localparam logic [PLACE_W-1:0] PLACE_ONES      = 2'd3;

   // Letter role inside one decimal place
   typedef enum logic [1:0] {
      ROLE_ONE  = 2'd0,
      ROLE_FIVE = 2'd1,
      ROLE_TEN  = 2'd2
   } role_type;

   // Decimal digits of one number, index 0 = thousands
   typedef struct packed {
      logic                             error;
      logic [PLACES-1:0][DIGIT_W-1:0]   digits;
   } item_type;

   function automatic logic [UNIT_W-1:0] place_unit(input logic [PLACE_W-1:0] place);
      logic [UNIT_W-1:0] unit;
      case (place)
         PLACE_THOUSANDS: unit = 10'd1000;
         PLACE_HUNDREDS:  unit = 10'd100;
         PLACE_TENS:      unit = 10'd10;
         default:         unit = 10'd1;
      endcase
      return unit;
   endfunction

   // Number of letters that spell one decimal digit
   function automatic logic [PLEN_W-1:0] pattern_len(input logic [DIGIT_W-1:0] d);
      logic [PLEN_W-1:0] len;
      case (d)
         4'd1, 4'd5:       len = 3'd1;
         4'd2, 4'd4, 4'd6,
         4'd9:             len = 3'd2;
         4'd3, 4'd7:       len = 3'd3;
         4'd8:             len = 3'd4;
         default:          len = 3'd0;
      endcase
      return len;
   endfunction

   // Role of letter k within the spelling of digit d
   function automatic role_type pattern_role(input logic [DIGIT_W-1:0] d,
                                             input logic [1:0]         k);
      role_type role;
      case (d)
         4'd4:                   role = (k == 2'd0) ? ROLE_ONE  : ROLE_FIVE;
         4'd5:                   role = ROLE_FIVE;
         4'd6, 4'd7, 4'd8:       role = (k == 2'd0) ? ROLE_FIVE : ROLE_ONE;
         4'd9:                   role = (k == 2'd0) ? ROLE_ONE  : ROLE_TEN;
         default:                role = ROLE_ONE;
      endcase
      return role;
   endfunction

   function automatic logic [SYM_W-1:0] role_symbol(input logic [PLACE_W-1:0] place,
                                                    input role_type            role);
      logic [SYM_W-1:0] sym;
      sym = SYM_M;
      case (place)
         PLACE_THOUSANDS: sym = SYM_M;
         PLACE_HUNDREDS: begin
            case (role)
               ROLE_ONE:  sym = SYM_C;
               ROLE_FIVE: sym = SYM_D;
               default:   sym = SYM_M;
            endcase
         end
         PLACE_TENS: begin
            case (role)
               ROLE_ONE:  sym = SYM_X;
               ROLE_FIVE: sym = SYM_L;
               default:   sym = SYM_C;
            endcase
         end
         default: begin
            case (role)
               ROLE_ONE:  sym = SYM_I;
               ROLE_FIVE: sym = SYM_V;
               default:   sym = SYM_X;
            endcase
         end
      endcase
      return sym;
   endfunction

endpackage

// ===== rtl/itr_if.sv =====
// ----------------------------------------------------------------------------
// itr_if - request and response channel interfaces
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface itr_req_if
   import itr_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface itr_rsp_if
   import itr_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             last;
   logic             error;

   modport source (output valid, output symbol, output last, output error, input ready);
   modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

// ===== rtl/itr_front.sv =====
// ----------------------------------------------------------------------------
// itr_front - request intake and decimal split
// Range-checks each number and splits an in-range one into four decimal digits, one
// place per cycle, then hands the result to the queue.
// ----------------------------------------------------------------------------
module itr_front
   import itr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   itr_req_if.sink       req_chan,
   output logic          push_valid,
   input  logic          push_ready,
   output item_type      push_item
);

   typedef enum logic [2:0] {
      F_IDLE  = 3'b001,
      F_SPLIT = 3'b010,
      F_PUSH  = 3'b100
   } front_state_type;

   front_state_type             state_ff, state_in;
   logic [NUM_W-1:0]            rest_ff, rest_in;
   logic [PLACE_W-1:0]          place_ff, place_in;
   item_type                    item_ff, item_in;

   logic                        req_fire;
   logic                        out_of_range;
   logic [DIGIT_W-1:0]          digit;
   logic [UNIT_W+3:0]           unit_wide;
   logic [UNIT_W+3:0]           taken;

   assign req_chan.ready = (state_ff == F_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign out_of_range   = (req_chan.number == '0) || (req_chan.number > ROMAN_MAX);
   assign push_valid     = (state_ff == F_PUSH);
   assign push_item      = item_ff;

   // Largest digit whose multiple of the place unit fits in the remainder
   always_comb begin
      unit_wide = (UNIT_W+4)'(place_unit(place_ff));
      digit     = '0;
      for (int m = 1; m <= 9; m++) begin
         if ((UNIT_W+4)'(rest_ff) >= (UNIT_W+4)'(m) * unit_wide) begin
            digit = DIGIT_W'(m);
         end
      end
      taken = (UNIT_W+4)'(digit) * unit_wide;
   end

   // Sequencing
   always_comb begin
      state_in = state_ff;
      rest_in  = rest_ff;
      place_in = place_ff;
      item_in  = item_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_fire) begin
               rest_in       = req_chan.number;
               place_in      = PLACE_THOUSANDS;
               item_in.error = out_of_range;
               item_in.digits = '0;
               state_in      = out_of_range ? F_PUSH : F_SPLIT;
            end
         end
         F_SPLIT: begin
            item_in.digits[place_ff] = digit;
            rest_in  = NUM_W'((UNIT_W+4)'(rest_ff) - taken);
            place_in = place_ff + 1'b1;
            if (place_ff == PLACE_ONES) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff  <= rest_in;
      place_ff <= place_in;
      item_ff  <= item_in;
   end

endmodule

// ===== rtl/itr_queue.sv =====
// ----------------------------------------------------------------------------
// itr_queue - small FIFO between front and back
// Holds split numbers so that intake and letter output stall independently.
// ----------------------------------------------------------------------------
module itr_queue
   import itr_pkg::*;
#(
   parameter int DEPTH = 2   // 2 or more
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  item_type  push_item,
   output logic      pop_valid,
   input  logic      pop_ready,
   output item_type  pop_item
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type            slot_ff [DEPTH];
   logic [IDX_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/itr_back.sv =====
// ----------------------------------------------------------------------------
// itr_back - Roman letter sequencer
// Walks the nonzero decimal places of one queued number and emits one ASCII
// letter per cycle unless rsp_chan stalls, into a registered response stage.
// ----------------------------------------------------------------------------
module itr_back
   import itr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  item_type   pop_item,
   itr_rsp_if.source  rsp_chan
);

   item_type            item_ff, item_in;
   logic [PLACE_W-1:0]  place_ff, place_in;
   logic [1:0]          chr_ff, chr_in;
   logic                busy_ff, busy_in;
   logic                out_valid_ff, out_valid_in;
   logic [SYM_W-1:0]    symbol_ff, symbol_in;
   logic                last_ff, last_in;
   logic                error_ff, error_in;

   logic [DIGIT_W-1:0]  cur_digit;
   logic [PLEN_W-1:0]   cur_len;
   logic                digit_done;
   logic                later_any;
   logic [PLACE_W-1:0]  next_place;
   logic [PLACE_W-1:0]  first_place;
   logic                item_done;
   logic                emit;
   logic                do_pop;

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.symbol = symbol_ff;
   assign rsp_chan.last   = last_ff;
   assign rsp_chan.error  = error_ff;

   assign cur_digit  = item_ff.digits[place_ff];
   assign cur_len    = pattern_len(cur_digit);
   assign digit_done = (PLEN_W'(chr_ff) + 1'b1) == cur_len;

   // Next nonzero place after the current one, and first one of a new number
   always_comb begin
      later_any   = 1'b0;
      next_place  = place_ff;
      first_place = PLACE_ONES;
      for (int p = PLACES - 1; p >= 0; p--) begin
         if (PLACE_W'(p) > place_ff && item_ff.digits[p] != '0) begin
            later_any  = 1'b1;
            next_place = PLACE_W'(p);
         end
         if (pop_item.digits[p] != '0) begin
            first_place = PLACE_W'(p);
         end
      end
   end

   assign item_done = item_ff.error || (digit_done && !later_any);
   assign emit      = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign pop_ready = !busy_ff || (emit && item_done);
   assign do_pop    = pop_valid && pop_ready;

   // Letter stepping and response stage
   always_comb begin
      item_in      = item_ff;
      place_in     = place_ff;
      chr_in       = chr_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      symbol_in    = symbol_ff;
      last_in      = last_ff;
      error_in     = error_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         symbol_in    = item_ff.error ? SYM_NONE
                      : role_symbol(place_ff, pattern_role(cur_digit, chr_ff));
         last_in      = item_done;
         error_in     = item_ff.error;
         if (digit_done) begin
            place_in = next_place;
            chr_in   = '0;
         end else begin
            chr_in   = chr_ff + 1'b1;
         end
         if (item_done) begin
            busy_in = 1'b0;
         end
      end

      if (do_pop) begin
         item_in  = pop_item;
         place_in = first_place;
         chr_in   = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      place_ff  <= place_in;
      chr_ff    <= chr_in;
      symbol_ff <= symbol_in;
      last_ff   <= last_in;
      error_ff  <= error_in;
   end

endmodule

// ===== rtl/integer_to_roman_text.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman_text - binary integer to Roman numeral ASCII stream
// Front splits each number into decimal places, a queue decouples it from
// the back; it emits one letter per cycle unless stalled, highest place first.
//
//   channel    dir  payload                    meaning
//   req_chan   in   number[11:0]               value to convert (1..3999)
//   rsp_chan   out  symbol[7:0], last, error   one letter per transaction
//
// Front: intake, place split through one compare bank shared by all places
// (skipped for out-of-range numbers) and a push into the queue; no new number
// is taken before the last is pushed; intake waits while the queue is full.
// Back: one response transaction per cycle unless rsp_chan stalls, 1 to 15
// per number; loads when idle or as the last letter of a number goes out.
// Out-of-range numbers give a single transaction with error set.
// Reset clears control state only; stalls on rsp_chan back up into the queue.
// ----------------------------------------------------------------------------
module integer_to_roman_text
   import itr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic       clock,
   input  logic       reset,
   itr_req_if.sink    req_chan,
   itr_rsp_if.source  rsp_chan
);

   logic      push_valid, push_ready;
   item_type  push_item;
   logic      pop_valid, pop_ready;
   item_type  pop_item;

   itr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   itr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   itr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== dv/tb_integer_to_roman_text.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_roman_text - self-checking bench for the Roman numeral encoder
// Sends directed edge numbers, then random ones, about a hundred in all,
// through the request channel in bursts. Every accepted number is spelled out
// in Roman letters by a local greedy encoder. Each response transaction is
// compared with the oldest letter still expected. The response side stalls on
// its own changing pattern.
// ----------------------------------------------------------------------------
module tb_integer_to_roman_text;
   import itr_pkg::*;

   localparam int RANDOM_NUMBERS = 75;
   localparam int SETTLE_CYCLES  = 40;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int LETTERS_MAX    = 15;

   // One expected letter of a spelled number
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             error;
   } letter_type;

   // Number waiting to be sent; drain_first holds it until all letters are back
   typedef struct packed {
      logic [NUM_W-1:0] number;
      logic             drain_first;
   } send_type;

   logic clock;
   logic reset;

   itr_req_if req_chan ();
   itr_rsp_if rsp_chan ();

   integer_to_roman_text DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   send_type   pending_numbers[$];
   letter_type expected_letters[$];
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   logic       req_taken      = 1'b0;
   int         burst_left     = 0;
   int         gap_left       = 0;
   int         stall_cycle    = 0;

   // Greedy step table: weight, leading letter, trailing letter of a pair
   function automatic int step_weight(input int s);
      case (s)
         0: return 1000;  1: return 900;  2: return 500;  3: return 400;
         4: return 100;   5: return 90;   6: return 50;   7: return 40;
         8: return 10;    9: return 9;   10: return 5;   11: return 4;
         default: return 1;
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] step_lead(input int s);
      case (s)
         0: return SYM_M;  1, 3, 4: return SYM_C;  2: return SYM_D;
         5, 7, 8: return SYM_X;  6: return SYM_L;  10: return SYM_V;
         default: return SYM_I;
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] step_trail(input int s);
      case (s)
         1: return SYM_M;  3: return SYM_D;  5: return SYM_C;
         7: return SYM_L;  9: return SYM_X; 11: return SYM_V;
         default: return SYM_NONE;
      endcase
   endfunction

   // Spell one number and queue its letters
   function automatic void spell_number(input logic [NUM_W-1:0] value);
      int               rest;
      int               len;
      logic [SYM_W-1:0] text [LETTERS_MAX];
      letter_type       letter;
      rest = int'(value);
      len  = 0;
      if (rest == 0 || value > ROMAN_MAX) begin
         letter.symbol = SYM_NONE;
         letter.last   = 1'b1;
         letter.error  = 1'b1;
         expected_letters.push_back(letter);
         return;
      end
      for (int s = 0; s < 13; s++) begin
         while (rest >= step_weight(s) && len < LETTERS_MAX) begin
            text[len] = step_lead(s);
            len++;
            if (step_trail(s) != SYM_NONE && len < LETTERS_MAX) begin
               text[len] = step_trail(s);
               len++;
            end
            rest -= step_weight(s);
         end
      end
      for (int k = 0; k < len; k++) begin
         letter.symbol = text[k];
         letter.last   = (k == len - 1);
         letter.error  = 1'b0;
         expected_letters.push_back(letter);
      end
   endfunction

   // Clock, reset and known input levels from time zero
   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.number = '0;
      rsp_chan.ready = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("integer_to_roman_text: mismatch");
         $finish;
      end
   end

   // Request driver: bursts with random gaps, optional drain before an item
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid  <= 1'b0;
         req_chan.number <= '0;
      end else if (req_chan.valid && !req_taken) begin
         // hold the offered transaction
      end else if (gap_left > 0) begin
         req_chan.valid <= 1'b0;
         gap_left--;
      end else if (pending_numbers.size() > 0 &&
                   !(pending_numbers[0].drain_first && expected_letters.size() > 0)) begin
         req_chan.valid  <= 1'b1;
         req_chan.number <= pending_numbers[0].number;
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left--;
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Response stall pattern: free-running, light random, then sparse phases
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_cycle <= stall_cycle + 1;
         case ((stall_cycle / 60) % 3)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_chan.ready <= (stall_cycle % 5 == 0) || ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   // Monitor: predict on request transactions, check response transactions
   always @(posedge clock) begin
      letter_type want;
      req_taken <= req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         spell_number(req_chan.number);
         if (pending_numbers.size() > 0)
            void'(pending_numbers.pop_front());
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_letters.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            $display("%0t: unexpected response symbol=%h last=%b error=%b", $time,
                     rsp_chan.symbol, rsp_chan.last, rsp_chan.error);
         end else begin
            want = expected_letters.pop_front();
            if (rsp_chan.symbol !== want.symbol || rsp_chan.last !== want.last ||
                rsp_chan.error !== want.error) begin
               mismatch_count <= mismatch_count + 1;
               $display("%0t: expected symbol=%h last=%b error=%b, got symbol=%h last=%b error=%b",
                        $time, want.symbol, want.last, want.error,
                        rsp_chan.symbol, rsp_chan.last, rsp_chan.error);
            end
         end
      end
   end

   // Build the stimulus, release reset, wait for the queues to empty
   initial begin
      int       pick;
      int       digit_sum;
      send_type item;
      int       directed [25];

      directed = '{1, 4, 5, 9, 10, 40, 50, 90, 100, 400, 500, 900,
                   1000, 3888, 3999, 0, 4000, 4095, 2048, 1365,
                   2730, 3, 444, 1994, 2};

      // edge values, every subtractive pair, longest run, out-of-range codes
      foreach (directed[i]) begin
         item.number      = directed[i][NUM_W-1:0];
         item.drain_first = (i == 13 || i == 15);
         pending_numbers.push_back(item);
      end

      // random numbers, mostly in range, with some out-of-range noise
      for (int n = 0; n < RANDOM_NUMBERS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            item.number = ($urandom_range(0, 2) == 0) ? '0 : NUM_W'($urandom_range(4000, 4095));
         end else if (pick < 20) begin
            item.number = NUM_W'($urandom_range(1, 99));
         end else if (pick < 40) begin
            // digit-wise build to hit heavy digits such as 8 and 9
            digit_sum = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
                        $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
            item.number = (digit_sum == 0) ? NUM_W'(3888) : NUM_W'(digit_sum);
         end else begin
            item.number = NUM_W'($urandom_range(1, 3999));
         end
         item.drain_first = (n == RANDOM_NUMBERS / 2) || ($urandom_range(0, 29) == 0);
         pending_numbers.push_back(item);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_numbers.size() > 0)
         @(posedge clock);
      while (expected_letters.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_letters.size() == 0) begin
         $display("integer_to_roman_text: match");
      end else begin
         $display("integer_to_roman_text: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/itr_pkg.sv
rtl/itr_if.sv
rtl/itr_front.sv
rtl/itr_queue.sv
rtl/itr_back.sv
rtl/integer_to_roman_text.sv
dv/tb_integer_to_roman_text.sv
